// ===== sv/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// shared types and constants of the merge sort engine
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

   // width of one stored element
   localparam int DATA_W = 32;

   // default capacity of one set
   localparam int DEPTH_DEFAULT = 64;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,     // collecting beats
      ST_PASS,     // start of a merge pass
      ST_RUN_A,    // fetch head of the left run
      ST_RUN_B,    // fetch head of the right run
      ST_MERGE,    // one element merged per cycle
      ST_EMIT_RD,  // prime the read for emission
      ST_EMIT      // one result beat per cycle
   } state_type;

   // write enables toward the two element memories
   typedef struct packed {
      logic wr_en0;
      logic wr_en1;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== sv/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
   parameter int DEPTH = mse_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [mse_pkg::DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [mse_pkg::DATA_W-1:0] rd_data
);

   logic [mse_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [mse_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/mse_seq.sv =====
// ----------------------------------------------------------------------------
// mse_seq
// load, bottom-up merge passes between two memories, and emission
// ----------------------------------------------------------------------------
`default_nettype none

module mse_seq #(
   parameter int DEPTH = mse_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [mse_pkg::DATA_W-1:0] req_value,
   input  wire logic                              req_last_in,
   output logic                                   rsp_strobe,
   output logic signed [mse_pkg::DATA_W-1:0]      rsp_sorted_value,
   output logic                                   rsp_last_out,
   output logic                                   rsp_overflow,
   output mse_pkg::mem_ctl_type                   mem_ctl,
   output logic [AW-1:0]                          wr_addr,
   output logic [mse_pkg::DATA_W-1:0]             wr_data,
   output logic [AW-1:0]                          rd_addr,
   input  wire logic [mse_pkg::DATA_W-1:0]        rd_data0,
   input  wire logic [mse_pkg::DATA_W-1:0]        rd_data1
);

   localparam int W_W   = CNT_W + 1;
   localparam int SUM_W = CNT_W + 3;

   mse_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             src_ff, src_in;
   logic [W_W-1:0]   w_ff, w_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             a_fresh_ff, a_fresh_in;
   logic             b_fresh_ff, b_fresh_in;
   logic [mse_pkg::DATA_W-1:0] a_val_ff, a_val_in;
   logic [mse_pkg::DATA_W-1:0] b_val_ff, b_val_in;

   logic [mse_pkg::DATA_W-1:0] rd_q;
   logic [mse_pkg::DATA_W-1:0] a_head, b_head;
   logic [SUM_W-1:0] mid_sum, hi_sum, n_ext;
   logic [CNT_W-1:0] mid_clip, hi_clip;
   logic [CNT_W-1:0] a_inc, b_inc, k_inc;
   logic             a_ok, b_ok, take_a;

   assign rd_q    = src_ff ? rd_data1 : rd_data0;
   assign a_head  = a_fresh_ff ? rd_q : a_val_ff;
   assign b_head  = b_fresh_ff ? rd_q : b_val_ff;
   assign n_ext   = SUM_W'(count_ff);
   assign mid_sum = SUM_W'(lo_ff) + SUM_W'(w_ff);
   assign hi_sum  = SUM_W'(lo_ff) + (SUM_W'(w_ff) << 1);
   assign mid_clip = (mid_sum > n_ext) ? count_ff : mid_sum[CNT_W-1:0];
   assign hi_clip  = (hi_sum > n_ext) ? count_ff : hi_sum[CNT_W-1:0];
   assign a_inc  = a_ff + CNT_W'(1);
   assign b_inc  = b_ff + CNT_W'(1);
   assign k_inc  = k_ff + CNT_W'(1);
   assign a_ok   = (a_ff < mid_ff);
   assign b_ok   = (b_ff < hi_ff);
   // left run wins ties
   assign take_a = a_ok && (!b_ok || ($signed(a_head) <= $signed(b_head)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mse_pkg::ST_LOAD;
         count_ff   <= '0;
         drop_ff    <= 1'b0;
         src_ff     <= 1'b0;
         w_ff       <= '0;
         lo_ff      <= '0;
         mid_ff     <= '0;
         hi_ff      <= '0;
         a_ff       <= '0;
         b_ff       <= '0;
         k_ff       <= '0;
         a_fresh_ff <= 1'b0;
         b_fresh_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         drop_ff    <= drop_in;
         src_ff     <= src_in;
         w_ff       <= w_in;
         lo_ff      <= lo_in;
         mid_ff     <= mid_in;
         hi_ff      <= hi_in;
         a_ff       <= a_in;
         b_ff       <= b_in;
         k_ff       <= k_in;
         a_fresh_ff <= a_fresh_in;
         b_fresh_ff <= b_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      a_val_ff <= a_val_in;
      b_val_ff <= b_val_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      src_in     = src_ff;
      w_in       = w_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      a_fresh_in = a_fresh_ff;
      b_fresh_in = b_fresh_ff;
      a_val_in   = a_val_ff;
      b_val_in   = b_val_ff;

      busy             = 1'b1;
      rsp_strobe       = 1'b0;
      rsp_sorted_value = $signed(rd_q);
      rsp_last_out     = 1'b0;
      rsp_overflow     = drop_ff;
      mem_ctl          = '0;
      wr_addr          = count_ff[AW-1:0];
      wr_data          = req_value;
      rd_addr          = lo_ff[AW-1:0];

      unique case (state_ff)
         mse_pkg::ST_LOAD: begin
            busy   = 1'b0;
            src_in = 1'b0;
            if (start) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  mem_ctl.wr_en0 = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_in) begin
                  w_in     = W_W'(1);
                  state_in = mse_pkg::ST_PASS;
               end
            end
         end

         mse_pkg::ST_PASS: begin
            lo_in = '0;
            if (w_ff >= W_W'(count_ff)) begin
               state_in = mse_pkg::ST_EMIT_RD;
            end else begin
               state_in = mse_pkg::ST_RUN_A;
            end
         end

         mse_pkg::ST_RUN_A: begin
            if (lo_ff >= count_ff) begin
               // pass finished, roles of the memories swap
               src_in   = ~src_ff;
               w_in     = w_ff << 1;
               state_in = mse_pkg::ST_PASS;
            end else begin
               rd_addr  = lo_ff[AW-1:0];
               a_in     = lo_ff;
               k_in     = lo_ff;
               mid_in   = mid_clip;
               hi_in    = hi_clip;
               b_in     = mid_clip;
               state_in = mse_pkg::ST_RUN_B;
            end
         end

         mse_pkg::ST_RUN_B: begin
            a_val_in   = rd_q;
            rd_addr    = b_ff[AW-1:0];
            a_fresh_in = 1'b0;
            b_fresh_in = 1'b1;
            state_in   = mse_pkg::ST_MERGE;
         end

         mse_pkg::ST_MERGE: begin
            a_val_in = a_head;
            b_val_in = b_head;
            wr_addr  = k_ff[AW-1:0];
            wr_data  = take_a ? a_head : b_head;
            mem_ctl.wr_en0 = src_ff;
            mem_ctl.wr_en1 = ~src_ff;
            k_in = k_inc;
            if (take_a) begin
               a_in       = a_inc;
               rd_addr    = a_inc[AW-1:0];
               a_fresh_in = 1'b1;
               b_fresh_in = 1'b0;
            end else begin
               b_in       = b_inc;
               rd_addr    = b_inc[AW-1:0];
               a_fresh_in = 1'b0;
               b_fresh_in = 1'b1;
            end
            if (k_inc == hi_ff) begin
               lo_in    = hi_ff;
               state_in = mse_pkg::ST_RUN_A;
            end
         end

         mse_pkg::ST_EMIT_RD: begin
            rd_addr  = '0;
            k_in     = '0;
            state_in = mse_pkg::ST_EMIT;
         end

         mse_pkg::ST_EMIT: begin
            rsp_strobe   = 1'b1;
            rsp_last_out = (k_inc == count_ff);
            rd_addr      = k_inc[AW-1:0];
            k_in         = k_inc;
            if (k_inc == count_ff) begin
               count_in = '0;
               drop_in  = 1'b0;
               state_in = mse_pkg::ST_LOAD;
            end
         end

         default: begin
            state_in = mse_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/merge_sort_engine_top.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine_top
// collects a set of signed values and returns them in ascending order
// ----------------------------------------------------------------------------
// usage
//   input beats: drive req_value / req_last_in with start; a beat is taken
//     at a clock edge where start is high and busy is low
//   while collecting, busy stays low and one beat is stored per start cycle
//   a beat with req_last_in closes the set; busy rises and the set is sorted
//     by bottom-up merge passes, ping-ponging between two memories with one
//     element merged per cycle (widths 1, 2, 4, ... until a run covers the set)
//   each pass fetches the heads of both runs of a pair before merging it,
//     and a check opens and closes the pass; after the last pass one more
//     check and a read lead into emission
//   results: one beat per cycle on rsp_* with rsp_strobe high, in ascending
//     order, rsp_last_out on the final beat, rsp_overflow on every beat of a
//     set that had more than DEPTH values (the extra values are dropped)
//   the receiver cannot stall; beats appear back to back and busy falls in
//     the cycle after the final beat
//   reset (synchronous, active high) empties the set and returns to collecting;
//     memory contents are left as they are and never read before written
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_engine_top #(
   parameter int DEPTH = mse_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [mse_pkg::DATA_W-1:0] req_value,
   input  wire logic                              req_last_in,
   output logic                                   rsp_strobe,
   output logic signed [mse_pkg::DATA_W-1:0]      rsp_sorted_value,
   output logic                                   rsp_last_out,
   output logic                                   rsp_overflow
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // both memories share address and data; write enables pick the target
   mse_pkg::mem_ctl_type       mem_ctl;
   logic [AW-1:0]              wr_addr;
   logic [mse_pkg::DATA_W-1:0] wr_data;
   logic [AW-1:0]              rd_addr;
   logic [mse_pkg::DATA_W-1:0] rd_data0;
   logic [mse_pkg::DATA_W-1:0] rd_data1;

   // sequencer: load, merge passes, emission
   mse_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CNT_W (CNT_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .mem_ctl          (mem_ctl),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .rd_data0         (rd_data0),
      .rd_data1         (rd_data1)
   );

   // element store: loaded with the incoming set, even passes read it
   mse_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram0 (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en0),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   // merge scratch: target of even passes, source of odd ones
   mse_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram1 (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en1),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

endmodule

`default_nettype wire

// ===== sv/mse_checker.sv =====
// ----------------------------------------------------------------------------
// mse_checker
// port-level checks of the merge sort engine
// ----------------------------------------------------------------------------
`default_nettype none

module mse_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_last_in,
   input wire logic rsp_strobe,
   input wire logic rsp_last_out,
   input wire logic rsp_overflow
);

   // results only come out while a set is being handled
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   // a beat that does not close the set keeps the engine collecting
   a_collect: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_in) |=> !busy)
      else $error("engine left collecting on a non-final beat");

   // closing the set starts the sort with no result in the next cycle
   a_close: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_in) |=> (busy && !rsp_strobe))
      else $error("set close did not start the sort");

   // result beats of one set run back to back with a steady overflow flag
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_out) |=> (rsp_strobe && $stable(rsp_overflow)))
      else $error("gap or overflow change inside a result burst");

   // the final beat releases the engine
   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_out) |=> !busy)
      else $error("engine still busy after the final beat");

endmodule

bind merge_sort_engine_top mse_checker u_mse_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_last_in  (req_last_in),
   .rsp_strobe   (rsp_strobe),
   .rsp_last_out (rsp_last_out),
   .rsp_overflow (rsp_overflow)
);

`default_nettype wire

// ===== tb/sort_board_pkg.sv =====
// ----------------------------------------------------------------------------
// sort_board_pkg
// scoreboard for the merge sort engine: predicts and checks sorted beats
// ----------------------------------------------------------------------------
`default_nettype none

package sort_board_pkg;

   localparam int DATA_W = mse_pkg::DATA_W;

   typedef struct {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } sorted_beat_type;

   class sorted_set_board_type;

      // capacity of one set, same as the instance in the bench
      localparam int CAP = mse_pkg::DEPTH_DEFAULT;

      sorted_beat_type          expected_beats[$];
      logic signed [DATA_W-1:0] held_values [CAP];
      int                       held_count;
      bit                       set_dropped;
      int                       failures;

      function new();
         held_count  = 0;
         set_dropped = 0;
         failures    = 0;
      endfunction

      // store one accepted input beat; a closing beat sorts and queues the set
      function void note_beat(logic signed [DATA_W-1:0] value, logic last_in);
         logic signed [DATA_W-1:0] scratch [CAP];
         sorted_beat_type          beat;
         int                       run_w, lo, mid, hi, a, b, k;
         if (held_count < CAP) begin
            held_values[held_count] = value;
            held_count++;
         end else begin
            set_dropped = 1'b1;
         end
         if (!last_in) return;

         // bottom-up merge passes, left run wins ties
         for (run_w = 1; run_w < held_count; run_w *= 2) begin
            for (lo = 0; lo < held_count; lo += 2 * run_w) begin
               mid = (lo + run_w < held_count) ? lo + run_w : held_count;
               hi  = (lo + 2 * run_w < held_count) ? lo + 2 * run_w : held_count;
               a = lo;
               b = mid;
               for (k = lo; k < hi; k++) begin
                  if (b >= hi || (a < mid && held_values[a] <= held_values[b])) begin
                     scratch[k] = held_values[a];
                     a++;
                  end else begin
                     scratch[k] = held_values[b];
                     b++;
                  end
               end
            end
            for (k = 0; k < held_count; k++) held_values[k] = scratch[k];
         end

         for (k = 0; k < held_count; k++) begin
            beat.sorted_value = held_values[k];
            beat.last_out     = (k == held_count - 1);
            beat.overflow     = set_dropped;
            expected_beats.push_back(beat);
         end
         held_count  = 0;
         set_dropped = 1'b0;
      endfunction

      // compare one result beat with the oldest expectation
      function void check_beat(logic signed [DATA_W-1:0] sorted_value,
                               logic last_out, logic overflow);
         sorted_beat_type want;
         if (expected_beats.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, expected none, got value %0d last %b ovf %b",
                     $time, sorted_value, last_out, overflow);
            return;
         end
         want = expected_beats.pop_front();
         if (sorted_value !== want.sorted_value) begin
            failures++;
            $display("%0t: sorted_value mismatch, expected %0d, got %0d",
                     $time, want.sorted_value, sorted_value);
         end
         if (last_out !== want.last_out) begin
            failures++;
            $display("%0t: last_out mismatch, expected %b, got %b",
                     $time, want.last_out, last_out);
         end
         if (overflow !== want.overflow) begin
            failures++;
            $display("%0t: overflow mismatch, expected %b, got %b",
                     $time, want.overflow, overflow);
         end
      endfunction

   endclass

endpackage

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for merge_sort_engine_top
// ----------------------------------------------------------------------------
// sends sets of signed values through the command port and checks every
// sorted result beat against a software sort kept in a scoreboard; a short
// directed part covers extremes, duplicates and single-value sets, then
// random sets of mostly small size with a few full and overflowing ones
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W       = mse_pkg::DATA_W;
   localparam int CAP          = mse_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_BEATS = 300;
   // the limit leaves a wide margin over the time a full set takes from first
   // beat to last result
   localparam int CYCLE_LIMIT = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     req_last_in = 1'b0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_overflow;

   sort_board_pkg::sorted_set_board_type board;
   int                       beats_sent = 0;
   // window of input beats during which the sender never pauses
   int                       calm_from = 120;
   int                       calm_to   = 200;

   merge_sort_engine_top #(.DEPTH(CAP)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_last_in     (req_last_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_out    (rsp_last_out),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // result monitor: values are sampled before the edge updates them
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         board.check_beat(rsp_sorted_value, rsp_last_out, rsp_overflow);
   end

   // hard stop if the engine hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // mix of full-range, small clustered (lots of duplicates) and extreme values
   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 7))
         3, 4:    v = int'($urandom_range(0, 16)) - 8;
         5: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh7fff_ffff;
               1:       v = 32'sh8000_0000;
               2:       v = '0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // present one beat and hold it until the engine takes it
   task automatic send_beat(logic signed [DATA_W-1:0] value, logic last_in);
      bit calm;
      calm = (beats_sent >= calm_from && beats_sent < calm_to);
      // idle cycles: start stays low, decided afresh each cycle
      while (!calm && $urandom_range(0, 99) < 36) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_value   <= value;
      req_last_in <= last_in;
      // busy read here is the value the edge just sampled
      do @(posedge clock); while (busy !== 1'b0);
      board.note_beat(value, last_in);
      beats_sent++;
   endtask

   // send a whole set, closing it on its final value
   task automatic send_set(logic signed [DATA_W-1:0] values[$]);
      foreach (values[i]) send_beat(values[i], i == values.size() - 1);
   endtask

   task automatic send_random_set(int set_size);
      for (int i = 0; i < set_size; i++) send_beat(pick_value(), i == set_size - 1);
   endtask

   initial begin
      logic signed [DATA_W-1:0] dset[$];
      int                       set_index;
      int                       set_size;
      int                       pick;
      int                       drain;

      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a single most-negative value comes back as is
      dset = '{32'sh8000_0000};
      send_set(dset);
      // the two extremes in reverse order
      dset = '{32'sh7fff_ffff, 32'sh8000_0000};
      send_set(dset);
      // sign boundaries, alternating bit patterns and a duplicate
      dset = '{0, -1, 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_5555,
               32'shaaaa_aaaa, -1};
      send_set(dset);
      // all equal
      dset = '{5, 5, 5};
      send_set(dset);
      // already ascending, odd length
      dset = '{-3, -2, -1, 0, 1, 2, 3};
      send_set(dset);
      // strictly descending
      dset = '{3, 2, 1};
      send_set(dset);

      // random sets, mostly small; a few exactly full or overflowing
      set_index = 0;
      calm_from = beats_sent + 120;
      calm_to   = beats_sent + 200;
      while (beats_sent < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (set_index == 2)
            set_size = CAP;                           // exactly full
         else if (set_index == 5)
            set_size = CAP + 1;                       // closing value is dropped
         else if (set_index == 9)
            set_size = CAP + 5;                       // several dropped
         else if (pick < 70)
            set_size = $urandom_range(1, 8);
         else if (pick < 90)
            set_size = $urandom_range(9, 24);
         else if (pick < 96)
            set_size = $urandom_range(25, CAP - 1);
         else
            set_size = $urandom_range(CAP - 2, CAP + 4);
         send_random_set(set_size);
         set_index++;
      end
      start       <= 1'b0;
      req_last_in <= 1'b0;

      // drain: every set was closed, so all expectations must arrive
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (board.failures == 0 && board.expected_beats.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
